FILE: rtl/bmmp_pkg.sv
// Shared types, constants and state encodings for the Berlekamp-Massey block.
package bmmp_pkg;

    localparam int MAX_TERMS  = 32;
    localparam int VALUE_BITS = 31;
    localparam int PLEN       = MAX_TERMS + 1;
    localparam int TIDX_W     = $clog2(MAX_TERMS);
    localparam int PIDX_W     = $clog2(PLEN);
    localparam int LEN_W      = $clog2(PLEN + 1);
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int DEG_W      = 6;

    localparam logic [VALUE_BITS-1:0] PRIME_RESET = VALUE_BITS'(998244353);

    typedef struct packed {
        logic [VALUE_BITS-1:0] term_value;
        logic                  last_term;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] coeff_value;
        logic [DEG_W-1:0]      coeff_degree;
        logic                  last_coeff;
        logic                  overflow;
    } out_word_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_RED,
        M_MUL
    } mul_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TRED,
        S_TSTORE,
        S_DRD,
        S_DMUL,
        S_DACC,
        S_SHIFT,
        S_XSQ,
        S_XSQD,
        S_XML,
        S_XMLD,
        S_FMUL,
        S_FSET,
        S_URD,
        S_URED,
        S_UCSET,
        S_UWR,
        S_UEND,
        S_FIN,
        S_ERD,
        S_ERED,
        S_EOUT,
        S_WAIT
    } seq_state_t;

endpackage

FILE: rtl/bmmp_mulmod.sv
// Bit-serial modular multiplier: reduces operand a, then forms a*b mod p.
module bmmp_mulmod (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bmmp_pkg::VALUE_BITS-1:0]   a,
    input  logic [bmmp_pkg::VALUE_BITS-1:0]   b,
    input  logic [bmmp_pkg::VALUE_BITS-1:0]   p,
    output logic                              done,
    output logic [bmmp_pkg::VALUE_BITS-1:0]   res
);

    localparam int VW = bmmp_pkg::VALUE_BITS;

    bmmp_pkg::mul_state_t state_reg, state_next;
    logic [bmmp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic [VW-1:0] a_reg, a_next;
    logic [VW-1:0] b_reg, b_next;
    logic [VW-1:0] ar_reg, ar_next;
    logic [VW-1:0] r_reg, r_next;
    logic [VW-1:0] p_reg, p_next;
    logic [VW:0]   red_t;
    logic [VW:0]   dbl_t;
    logic [VW:0]   dbl_m;
    logic [VW:0]   acc_t;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= bmmp_pkg::M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        ar_reg <= ar_next;
        r_reg  <= r_next;
        p_reg  <= p_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        ar_next    = ar_reg;
        r_next     = r_reg;
        p_next     = p_reg;
        red_t      = {r_reg, a_reg[VW-1]};
        if (red_t >= {1'b0, p_reg}) begin
            red_t = red_t - {1'b0, p_reg};
        end
        dbl_t = {r_reg, 1'b0};
        if (dbl_t >= {1'b0, p_reg}) begin
            dbl_m = dbl_t - {1'b0, p_reg};
        end else begin
            dbl_m = dbl_t;
        end
        acc_t = dbl_m + (b_reg[VW-1] ? {1'b0, ar_reg} : '0);
        if (acc_t >= {1'b0, p_reg}) begin
            acc_t = acc_t - {1'b0, p_reg};
        end
        unique case (state_reg)
            bmmp_pkg::M_IDLE: begin
                if (start) begin
                    a_next     = a;
                    b_next     = b;
                    p_next     = p;
                    r_next     = '0;
                    cnt_next   = bmmp_pkg::CNT_W'(VW - 1);
                    state_next = bmmp_pkg::M_RED;
                end
            end
            bmmp_pkg::M_RED: begin
                r_next = red_t[VW-1:0];
                a_next = {a_reg[VW-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    ar_next    = red_t[VW-1:0];
                    r_next     = '0;
                    cnt_next   = bmmp_pkg::CNT_W'(VW - 1);
                    state_next = bmmp_pkg::M_MUL;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            bmmp_pkg::M_MUL: begin
                r_next = acc_t[VW-1:0];
                b_next = {b_reg[VW-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = bmmp_pkg::M_IDLE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: begin
                state_next = bmmp_pkg::M_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign res  = r_reg;

endmodule

FILE: rtl/bmmp_polyram.sv
// Polynomial coefficient memory with per-entry valid bits; unwritten entries read 1, 0, 0, ...
module bmmp_polyram (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clr,
    input  logic                              we,
    input  logic [bmmp_pkg::PIDX_W-1:0]       waddr,
    input  logic [bmmp_pkg::VALUE_BITS-1:0]   wdata,
    input  logic                              re,
    input  logic [bmmp_pkg::PIDX_W-1:0]       raddr,
    output logic [bmmp_pkg::VALUE_BITS-1:0]   rdata
);

    logic [bmmp_pkg::VALUE_BITS-1:0] mem [bmmp_pkg::PLEN];
    logic [bmmp_pkg::PLEN-1:0]       valid_reg;
    logic [bmmp_pkg::VALUE_BITS-1:0] rdata_reg;
    logic                            rvalid_reg;
    logic                            rzero_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            rzero_reg  <= 1'b0;
        end else begin
            if (clr) begin
                valid_reg <= '0;
            end else if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rvalid_reg <= valid_reg[raddr];
                rzero_reg  <= (raddr == '0);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg
                 : (rzero_reg ? bmmp_pkg::VALUE_BITS'(1) : '0);

endmodule

FILE: rtl/berlekamp_massey_mod_prime.sv
// Top level: Berlekamp-Massey over a prime field with serial modular arithmetic.
//
// Input channel (in_valid/in_ready/in_data) takes one sequence term per word.
// in_ready is high only while the sequencer is idle; each term is reduced mod p,
// stored, and runs one iteration before the next word is taken.
// Every modular product goes through one shared bit-serial multiplier, which is
// issued, reduces the first operand, multiplies and then hands over the result.
// A term computes its discrepancy over the taps of the connection polynomial; a
// nonzero discrepancy adds an inverse of the previous discrepancy (raised to p-2),
// a scale factor and an update of the polynomial up to its new length.
// On a term marked last the coefficients of Q(x) leave on out_valid/out_ready/
// out_data in ascending degree; a stalled word holds in the output register
// and the sequencer waits. After the last coefficient the sequence state clears.
// Terms beyond capacity are dropped and flag overflow on every output word.
// cfg_valid/cfg_data write the prime modulus; cfg_ready is always high.
// Reset clears the sequence state at once and loads p = 998244353.
module berlekamp_massey_mod_prime (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bmmp_pkg::in_word_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bmmp_pkg::out_word_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmmp_pkg::VALUE_BITS-1:0]   cfg_data
);

    localparam int VW = bmmp_pkg::VALUE_BITS;
    localparam int LW = bmmp_pkg::LEN_W;
    localparam int PW = bmmp_pkg::PIDX_W;
    localparam int TW = bmmp_pkg::TIDX_W;

    bmmp_pkg::seq_state_t state_reg, state_next;
    bmmp_pkg::seq_state_t ret_reg, ret_next;

    logic [VW-1:0] pmod_reg;
    logic [VW-1:0] term_reg, term_next;
    logic          last_reg, last_next;
    logic [LW-1:0] tc_reg, tc_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] clen_reg, clen_next;
    logic [LW-1:0] plen_reg, plen_next;
    logic [LW-1:0] m_reg, m_next;
    logic [LW-1:0] shift_reg, shift_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [VW-1:0] pd_reg, pd_next;
    logic [VW-1:0] x_reg, x_next;
    logic [VW-1:0] r_reg, r_next;
    logic [VW-1:0] f_reg, f_next;
    logic [VW-1:0] c_reg, c_next;
    logic [bmmp_pkg::CNT_W-1:0] bit_reg, bit_next;
    logic          role_reg, role_next;
    logic          swap_reg, swap_next;

    logic                 out_valid_reg, out_valid_next;
    bmmp_pkg::out_word_t  out_reg, out_next;

    logic [VW-1:0] pm;
    logic [VW-1:0] pexp;
    logic [VW:0]   sum_t;
    logic [VW:0]   dif_t;
    logic [LW-1:0] m_calc;
    logic [LW-1:0] tsub;
    logic [LW-1:0] psub;

    logic          mul_start;
    logic [VW-1:0] mul_a;
    logic [VW-1:0] mul_b;
    logic          mul_done;
    logic [VW-1:0] mul_res;

    logic [VW-1:0] term_mem [bmmp_pkg::MAX_TERMS];
    logic [VW-1:0] term_rd_reg;
    logic          tm_we;
    logic          tm_re;
    logic [TW-1:0] tm_raddr;

    logic          conn_re;
    logic          prev_re;
    logic [PW-1:0] conn_raddr;
    logic [PW-1:0] prev_raddr;
    logic [VW-1:0] conn_rd;
    logic [VW-1:0] prev_rd;
    logic [VW-1:0] prev_val;
    logic          poly_we;
    logic [VW-1:0] poly_wdata;
    logic          poly_clr;
    logic          tgt;
    logic          b0_re;
    logic          b1_re;
    logic [PW-1:0] b0_raddr;
    logic [PW-1:0] b1_raddr;
    logic [VW-1:0] b0_rdata;
    logic [VW-1:0] b1_rdata;

    assign pm        = (pmod_reg[VW-1:1] == '0) ? VW'(2) : pmod_reg;
    assign pexp      = pm - VW'(2);
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == bmmp_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    bmmp_mulmod u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (pm),
        .done  (mul_done),
        .res   (mul_res)
    );

    assign tgt      = role_reg ^ swap_reg;
    assign b0_re    = role_reg ? prev_re : conn_re;
    assign b1_re    = role_reg ? conn_re : prev_re;
    assign b0_raddr = role_reg ? prev_raddr : conn_raddr;
    assign b1_raddr = role_reg ? conn_raddr : prev_raddr;
    assign conn_rd  = role_reg ? b1_rdata : b0_rdata;
    assign prev_rd  = role_reg ? b0_rdata : b1_rdata;
    assign prev_val = (idx_reg >= shift_reg) ? prev_rd : '0;

    bmmp_polyram u_bank0 (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (poly_clr),
        .we    (poly_we & ~tgt),
        .waddr (idx_reg[PW-1:0]),
        .wdata (poly_wdata),
        .re    (b0_re),
        .raddr (b0_raddr),
        .rdata (b0_rdata)
    );

    bmmp_polyram u_bank1 (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (poly_clr),
        .we    (poly_we & tgt),
        .waddr (idx_reg[PW-1:0]),
        .wdata (poly_wdata),
        .re    (b1_re),
        .raddr (b1_raddr),
        .rdata (b1_rdata)
    );

    always_ff @(posedge clk) begin
        if (tm_we) begin
            term_mem[tc_reg[TW-1:0]] <= mul_res;
        end
        if (tm_re) begin
            term_rd_reg <= term_mem[tm_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pmod_reg <= bmmp_pkg::PRIME_RESET;
        end else if (cfg_valid && cfg_ready) begin
            pmod_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= bmmp_pkg::S_IDLE;
            ret_reg       <= bmmp_pkg::S_IDLE;
            tc_reg        <= '0;
            ovf_reg       <= 1'b0;
            clen_reg      <= LW'(1);
            plen_reg      <= LW'(1);
            shift_reg     <= '0;
            pd_reg        <= VW'(1);
            role_reg      <= 1'b0;
            swap_reg      <= 1'b0;
            idx_reg       <= '0;
            bit_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            tc_reg        <= tc_next;
            ovf_reg       <= ovf_next;
            clen_reg      <= clen_next;
            plen_reg      <= plen_next;
            shift_reg     <= shift_next;
            pd_reg        <= pd_next;
            role_reg      <= role_next;
            swap_reg      <= swap_next;
            idx_reg       <= idx_next;
            bit_reg       <= bit_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        term_reg <= term_next;
        m_reg    <= m_next;
        x_reg    <= x_next;
        r_reg    <= r_next;
        f_reg    <= f_next;
        c_reg    <= c_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        term_next      = term_reg;
        last_next      = last_reg;
        tc_next        = tc_reg;
        ovf_next       = ovf_reg;
        clen_next      = clen_reg;
        plen_next      = plen_reg;
        m_next         = m_reg;
        shift_next     = shift_reg;
        idx_next       = idx_reg;
        pd_next        = pd_reg;
        x_next         = x_reg;
        r_next         = r_reg;
        f_next         = f_reg;
        c_next         = c_reg;
        bit_next       = bit_reg;
        role_next      = role_reg;
        swap_next      = swap_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mul_start      = 1'b0;
        mul_a          = conn_rd;
        mul_b          = VW'(1);
        tm_we          = 1'b0;
        tm_re          = 1'b0;
        conn_re        = 1'b0;
        prev_re        = 1'b0;
        poly_we        = 1'b0;
        poly_clr       = 1'b0;
        tsub           = tc_reg - LW'(1) - idx_reg;
        psub           = idx_reg - shift_reg;
        tm_raddr       = tsub[TW-1:0];
        conn_raddr     = idx_reg[PW-1:0];
        prev_raddr     = psub[PW-1:0];
        m_calc         = plen_reg + LW'(1);
        sum_t          = {1'b0, x_reg} + {1'b0, mul_res};
        if (sum_t >= {1'b0, pm}) begin
            sum_t = sum_t - {1'b0, pm};
        end
        if (c_reg >= mul_res) begin
            dif_t = {1'b0, c_reg} - {1'b0, mul_res};
        end else begin
            dif_t = {1'b0, c_reg} + {1'b0, pm} - {1'b0, mul_res};
        end
        poly_wdata = dif_t[VW-1:0];

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bmmp_pkg::S_IDLE: begin
                if (in_valid) begin
                    term_next = in_data.term_value;
                    last_next = in_data.last_term;
                    if (tc_reg < LW'(bmmp_pkg::MAX_TERMS)) begin
                        state_next = bmmp_pkg::S_TRED;
                    end else begin
                        ovf_next = 1'b1;
                        idx_next = '0;
                        state_next = in_data.last_term ? bmmp_pkg::S_ERD
                                                       : bmmp_pkg::S_IDLE;
                    end
                end
            end
            bmmp_pkg::S_TRED: begin
                mul_start  = 1'b1;
                mul_a      = term_reg;
                ret_next   = bmmp_pkg::S_TSTORE;
                state_next = bmmp_pkg::S_WAIT;
            end
            bmmp_pkg::S_TSTORE: begin
                tm_we      = 1'b1;
                tc_next    = tc_reg + LW'(1);
                idx_next   = '0;
                x_next     = '0;
                state_next = bmmp_pkg::S_DRD;
            end
            bmmp_pkg::S_DRD: begin
                if (idx_reg < clen_reg && idx_reg < tc_reg) begin
                    conn_re    = 1'b1;
                    tm_re      = 1'b1;
                    state_next = bmmp_pkg::S_DMUL;
                end else begin
                    state_next = bmmp_pkg::S_SHIFT;
                end
            end
            bmmp_pkg::S_DMUL: begin
                mul_start  = 1'b1;
                mul_b      = term_rd_reg;
                ret_next   = bmmp_pkg::S_DACC;
                state_next = bmmp_pkg::S_WAIT;
            end
            bmmp_pkg::S_DACC: begin
                x_next     = sum_t[VW-1:0];
                idx_next   = idx_reg + LW'(1);
                state_next = bmmp_pkg::S_DRD;
            end
            bmmp_pkg::S_SHIFT: begin
                m_next     = m_calc;
                shift_next = shift_reg + LW'(1);
                swap_next  = (clen_reg < m_calc);
                if (x_reg == '0) begin
                    plen_next  = m_calc;
                    state_next = bmmp_pkg::S_FIN;
                end else begin
                    r_next     = VW'(1);
                    bit_next   = bmmp_pkg::CNT_W'(VW - 1);
                    state_next = bmmp_pkg::S_XSQ;
                end
            end
            bmmp_pkg::S_XSQ: begin
                mul_start  = 1'b1;
                mul_a      = r_reg;
                mul_b      = r_reg;
                ret_next   = bmmp_pkg::S_XSQD;
                state_next = bmmp_pkg::S_WAIT;
            end
            bmmp_pkg::S_XSQD: begin
                r_next = mul_res;
                if (pexp[bit_reg]) begin
                    state_next = bmmp_pkg::S_XML;
                end else if (bit_reg == '0) begin
                    state_next = bmmp_pkg::S_FMUL;
                end else begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = bmmp_pkg::S_XSQ;
                end
            end
            bmmp_pkg::S_XML: begin
                mul_start  = 1'b1;
                mul_a      = r_reg;
                mul_b      = pd_reg;
                ret_next   = bmmp_pkg::S_XMLD;
                state_next = bmmp_pkg::S_WAIT;
            end
            bmmp_pkg::S_XMLD: begin
                r_next = mul_res;
                if (bit_reg == '0) begin
                    state_next = bmmp_pkg::S_FMUL;
                end else begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = bmmp_pkg::S_XSQ;
                end
            end
            bmmp_pkg::S_FMUL: begin
                mul_start  = 1'b1;
                mul_a      = x_reg;
                mul_b      = r_reg;
                ret_next   = bmmp_pkg::S_FSET;
                state_next = bmmp_pkg::S_WAIT;
            end
            bmmp_pkg::S_FSET: begin
                f_next     = mul_res;
                idx_next   = m_reg - LW'(1);
                state_next = bmmp_pkg::S_URD;
            end
            bmmp_pkg::S_URD: begin
                conn_re    = 1'b1;
                prev_re    = 1'b1;
                state_next = bmmp_pkg::S_URED;
            end
            bmmp_pkg::S_URED: begin
                mul_start  = 1'b1;
                ret_next   = bmmp_pkg::S_UCSET;
                state_next = bmmp_pkg::S_WAIT;
            end
            bmmp_pkg::S_UCSET: begin
                c_next     = mul_res;
                mul_start  = 1'b1;
                mul_a      = f_reg;
                mul_b      = prev_val;
                ret_next   = bmmp_pkg::S_UWR;
                state_next = bmmp_pkg::S_WAIT;
            end
            bmmp_pkg::S_UWR: begin
                poly_we = 1'b1;
                if (idx_reg == '0) begin
                    state_next = bmmp_pkg::S_UEND;
                end else begin
                    idx_next   = idx_reg - LW'(1);
                    state_next = bmmp_pkg::S_URD;
                end
            end
            bmmp_pkg::S_UEND: begin
                if (swap_reg) begin
                    plen_next  = clen_reg;
                    clen_next  = m_reg;
                    pd_next    = x_reg;
                    role_next  = ~role_reg;
                    shift_next = '0;
                end else begin
                    plen_next = m_reg;
                end
                swap_next  = 1'b0;
                state_next = bmmp_pkg::S_FIN;
            end
            bmmp_pkg::S_FIN: begin
                idx_next   = '0;
                state_next = last_reg ? bmmp_pkg::S_ERD : bmmp_pkg::S_IDLE;
            end
            bmmp_pkg::S_ERD: begin
                conn_re    = 1'b1;
                state_next = bmmp_pkg::S_ERED;
            end
            bmmp_pkg::S_ERED: begin
                mul_start  = 1'b1;
                ret_next   = bmmp_pkg::S_EOUT;
                state_next = bmmp_pkg::S_WAIT;
            end
            bmmp_pkg::S_EOUT: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next          = 1'b1;
                    out_next.coeff_value    = mul_res;
                    out_next.coeff_degree   = bmmp_pkg::DEG_W'(idx_reg);
                    out_next.last_coeff     = (idx_reg + LW'(1) == clen_reg);
                    out_next.overflow       = ovf_reg;
                    if (idx_reg + LW'(1) == clen_reg) begin
                        poly_clr   = 1'b1;
                        role_next  = 1'b0;
                        clen_next  = LW'(1);
                        plen_next  = LW'(1);
                        pd_next    = VW'(1);
                        tc_next    = '0;
                        ovf_next   = 1'b0;
                        shift_next = '0;
                        state_next = bmmp_pkg::S_IDLE;
                    end else begin
                        idx_next   = idx_reg + LW'(1);
                        state_next = bmmp_pkg::S_ERD;
                    end
                end
            end
            bmmp_pkg::S_WAIT: begin
                if (mul_done) begin
                    state_next = ret_reg;
                end
            end
            default: begin
                state_next = bmmp_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_tc_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tc_reg <= LW'(bmmp_pkg::MAX_TERMS))
        else $error("term count beyond capacity");

    a_clen_range: assert property (@(posedge clk) disable iff (!rst_n)
        clen_reg != '0 && clen_reg <= LW'(bmmp_pkg::PLEN))
        else $error("connection length out of range");

    a_shift_len: assert property (@(posedge clk) disable iff (!rst_n)
        shift_reg <= plen_reg)
        else $error("previous polynomial shift beyond its length");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == bmmp_pkg::S_WAIT)
        else $error("multiplier finished outside wait state");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bmmp_pkg::S_EOUT))
        else $error("output word loaded outside emit state");
`endif

endmodule
